// ===== rtl/core/i2cbe_pkg.sv =====
// shared constants and types of the i2c master bit engine
// used by the channel interfaces, the engine and its checker
package i2cbe_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int DELAY_WIDTH   = 12;
  localparam int BYTE_W        = BITS_PER_BYTE;
  localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);
  localparam int SHORT_W       = 10;
  localparam int LONG_W        = 12;
  localparam int LIMIT_W       = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;

  localparam logic [SHORT_W-1:0] SHORT_RST = SHORT_W'(5);
  localparam logic [LONG_W-1:0]  LONG_RST  = LONG_W'(30);
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(250);

  typedef enum logic [2:0] {
    FN_START = 3'd0,
    FN_STOP  = 3'd1,
    FN_WRITE = 3'd2,
    FN_WAIT  = 3'd3,
    FN_ACK   = 3'd4,
    FN_READ  = 3'd5
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT = 2'd0,
    CFG_LONG  = 2'd1,
    CFG_LIMIT = 2'd2
  } cfg_idx_t;

endpackage

// ===== rtl/core/i2cbe_if.sv =====
// tick and result channel interfaces of the i2c master bit engine
// depends on i2cbe_pkg
interface i2cbe_in_if;
  import i2cbe_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd_valid;
  func_t             func;
  logic [BYTE_W-1:0] tx_byte;
  logic              send_ack;
  logic              sda_in;

  modport source (output valid, cmd_valid, func, tx_byte, send_ack, sda_in, input ready);
  modport sink   (input valid, cmd_valid, func, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cbe_out_if;
  import i2cbe_pkg::*;
  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_value;
  logic              sda_enable;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] rx_byte;
  logic              ack_error;

  modport source (output valid, scl_level, sda_value, sda_enable, busy_res, done_res,
                  rx_byte, ack_error, input ready);
  modport sink   (input valid, scl_level, sda_value, sda_enable, busy_res, done_res,
                  rx_byte, ack_error, output ready);
endinterface

// ===== rtl/core/i2c_master_bit_engine.sv =====
// i2c master bit engine: one tick in, one line/status result out
// depends on i2cbe_pkg and the channel interfaces in i2cbe_if.sv
//
// usage
//   in_ch carries one time-base tick per transfer: sampled sda, and while
//   the engine is idle an optional command (start, stop, write byte, wait
//   ack, ack bit, read byte). commands that arrive while busy are dropped.
//   out_ch returns one result per tick: scl level, sda value and enable,
//   busy, a one-tick done pulse, the last read byte and the ack error flag.
//   cfg_we/cfg_index/cfg_wdata write the short delay, long delay and ack
//   timeout limit; write them only while no command is running.
//   latency: the result of a tick is on out_ch the cycle after its transfer.
//   throughput: one tick per cycle, set by the single state/result register
//   stage; the next tick is taken while the previous result is taken.
//   when out_ch stalls, the result holds and in_ch.ready drops until the
//   result is taken, so the tick timebase stretches with the stall.
//   reset: idle, scl high, sda driven high, delays 5/30, timeout limit 250,
//   no result pending.
module i2c_master_bit_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  i2cbe_in_if.sink                           in_ch,
  i2cbe_out_if.source                        out_ch,
  input  logic                               cfg_we,
  input  logic [i2cbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2cbe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import i2cbe_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B, PH_WR_SET, PH_WR_HI, PH_WR_LO,
    PH_WA_HI, PH_AK_A, PH_AK_B, PH_AK_C, PH_RD_SET, PH_RD_LO, PH_RD_HI
  } phase_t;

  logic [SHORT_W-1:0]     short_r;
  logic [LONG_W-1:0]      long_r;
  logic [LIMIT_W-1:0]     limit_r;

  phase_t                 phase_r, phase_nxt;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt, bit_inc;
  logic [BYTE_W-1:0]      shift_r, shift_nxt, shift_in;
  logic [DELAY_WIDTH-1:0] delay_r, delay_nxt;
  logic [DELAY_WIDTH-1:0] sd_ticks, ld_ticks;
  logic [LIMIT_W-1:0]     tmo_r, tmo_nxt;
  logic                   ack_flag_r, ack_flag_nxt;
  logic                   ack_choice_r, ack_choice_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   en_r, en_nxt;
  logic [BYTE_W-1:0]      rx_r, rx_nxt;
  logic                   done_r, done_nxt;
  logic                   out_valid_r;
  logic                   in_xfer;
  logic                   cmd_ok;

  function automatic logic [DELAY_WIDTH-1:0] clamp_delay(input logic [DELAY_WIDTH-1:0] d);
    logic [DELAY_WIDTH-1:0] r;
    r = (d == '0) ? DELAY_WIDTH'(1) : d;
    return r;
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= SHORT_RST;
      long_r  <= LONG_RST;
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SHORT: short_r <= cfg_wdata[SHORT_W-1:0];
        CFG_LONG:  long_r  <= cfg_wdata[LONG_W-1:0];
        CFG_LIMIT: limit_r <= cfg_wdata[LIMIT_W-1:0];
        default:   ;
      endcase
    end
  end

  assign sd_ticks = clamp_delay(DELAY_WIDTH'(short_r));
  assign ld_ticks = clamp_delay(DELAY_WIDTH'(long_r));

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  assign cmd_ok   = in_ch.cmd_valid && (in_ch.func <= FN_READ);
  assign bit_inc  = bit_cnt_r + BIT_CNT_W'(1);
  assign shift_in = {shift_r[BYTE_W-2:0], in_ch.sda_in};

  always_comb begin
    phase_nxt      = phase_r;
    bit_cnt_nxt    = bit_cnt_r;
    shift_nxt      = shift_r;
    delay_nxt      = delay_r;
    tmo_nxt        = tmo_r;
    ack_flag_nxt   = ack_flag_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    en_nxt         = en_r;
    rx_nxt         = rx_r;
    done_nxt       = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (cmd_ok) begin
        ack_flag_nxt   = 1'b0;
        bit_cnt_nxt    = '0;
        tmo_nxt        = '0;
        shift_nxt      = '0;
        ack_choice_nxt = in_ch.send_ack;
        case (in_ch.func)
          FN_START: begin
            scl_nxt = 1'b1; sda_nxt = 1'b1; en_nxt = 1'b1;
            phase_nxt = PH_ST_A; delay_nxt = ld_ticks;
          end
          FN_STOP: begin
            scl_nxt = 1'b0; sda_nxt = 1'b0; en_nxt = 1'b1;
            phase_nxt = PH_SP_A; delay_nxt = sd_ticks;
          end
          FN_WRITE: begin
            shift_nxt = in_ch.tx_byte; scl_nxt = 1'b0; en_nxt = 1'b1;
            phase_nxt = PH_WR_SET; delay_nxt = sd_ticks;
          end
          FN_WAIT: begin
            en_nxt = 1'b0; scl_nxt = 1'b1;
            phase_nxt = PH_WA_HI; delay_nxt = sd_ticks;
          end
          FN_ACK: begin
            scl_nxt = 1'b0; en_nxt = 1'b1;
            phase_nxt = PH_AK_A; delay_nxt = sd_ticks;
          end
          default: begin
            en_nxt = 1'b0;
            phase_nxt = PH_RD_SET; delay_nxt = ld_ticks;
          end
        endcase
      end
    end else if (delay_r > DELAY_WIDTH'(1)) begin
      delay_nxt = delay_r - DELAY_WIDTH'(1);
    end else begin
      case (phase_r)
        PH_ST_A: begin
          sda_nxt = 1'b0; phase_nxt = PH_ST_B; delay_nxt = sd_ticks;
        end
        PH_ST_B: begin
          scl_nxt = 1'b0; phase_nxt = PH_IDLE; done_nxt = 1'b1;
        end
        PH_SP_A: begin
          scl_nxt = 1'b1; phase_nxt = PH_SP_B; delay_nxt = ld_ticks;
        end
        PH_SP_B: begin
          sda_nxt = 1'b1; phase_nxt = PH_IDLE; done_nxt = 1'b1;
        end
        PH_WR_SET, PH_WR_LO: begin
          if (phase_r == PH_WR_LO && bit_cnt_r >= BIT_CNT_W'(BITS_PER_BYTE)) begin
            phase_nxt = PH_IDLE; done_nxt = 1'b1;
          end else begin
            sda_nxt     = shift_r[BYTE_W-1];
            shift_nxt   = {shift_r[BYTE_W-2:0], 1'b0};
            bit_cnt_nxt = bit_inc;
            scl_nxt     = 1'b1;
            phase_nxt   = PH_WR_HI; delay_nxt = sd_ticks;
          end
        end
        PH_WR_HI: begin
          scl_nxt = 1'b0; phase_nxt = PH_WR_LO; delay_nxt = sd_ticks;
        end
        PH_WA_HI: begin
          if (!in_ch.sda_in) begin
            scl_nxt = 1'b0; phase_nxt = PH_IDLE; done_nxt = 1'b1;
          end else if (tmo_r >= limit_r) begin
            // no ack: fall into the stop sequence
            ack_flag_nxt = 1'b1;
            scl_nxt = 1'b0; sda_nxt = 1'b0; en_nxt = 1'b1;
            phase_nxt = PH_SP_A; delay_nxt = sd_ticks;
          end else begin
            tmo_nxt   = tmo_r + LIMIT_W'(1);
            delay_nxt = sd_ticks;
          end
        end
        PH_AK_A: begin
          sda_nxt = !ack_choice_r; phase_nxt = PH_AK_B; delay_nxt = sd_ticks;
        end
        PH_AK_B: begin
          scl_nxt = 1'b1; phase_nxt = PH_AK_C; delay_nxt = sd_ticks;
        end
        PH_AK_C: begin
          scl_nxt = 1'b0; phase_nxt = PH_IDLE; done_nxt = 1'b1;
        end
        PH_RD_SET: begin
          scl_nxt = 1'b0; phase_nxt = PH_RD_LO; delay_nxt = sd_ticks;
        end
        PH_RD_LO: begin
          scl_nxt = 1'b1; phase_nxt = PH_RD_HI; delay_nxt = DELAY_WIDTH'(1);
        end
        PH_RD_HI: begin
          shift_nxt   = shift_in;
          bit_cnt_nxt = bit_inc;
          scl_nxt     = 1'b0;
          if (bit_inc >= BIT_CNT_W'(BITS_PER_BYTE)) begin
            rx_nxt = shift_in; en_nxt = 1'b1;
            phase_nxt = PH_AK_A; delay_nxt = sd_ticks;
          end else begin
            phase_nxt = PH_RD_LO; delay_nxt = sd_ticks;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_cnt_r    <= '0;
      shift_r      <= '0;
      delay_r      <= '0;
      tmo_r        <= '0;
      ack_flag_r   <= 1'b0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      en_r         <= 1'b1;
      rx_r         <= '0;
      done_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r      <= phase_nxt;
        bit_cnt_r    <= bit_cnt_nxt;
        shift_r      <= shift_nxt;
        delay_r      <= delay_nxt;
        tmo_r        <= tmo_nxt;
        ack_flag_r   <= ack_flag_nxt;
        ack_choice_r <= ack_choice_nxt;
        scl_r        <= scl_nxt;
        sda_r        <= sda_nxt;
        en_r         <= en_nxt;
        rx_r         <= rx_nxt;
        done_r       <= done_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl_level  = scl_r;
  assign out_ch.sda_value  = sda_r;
  assign out_ch.sda_enable = en_r;
  assign out_ch.busy_res   = (phase_r != PH_IDLE);
  assign out_ch.done_res   = done_r;
  assign out_ch.rx_byte    = rx_r;
  assign out_ch.ack_error  = ack_flag_r;

endmodule

// ===== rtl/core/i2cbe_checker.sv =====
// port-level checker for the i2c master bit engine and its bind
// depends on i2cbe_pkg and i2c_master_bit_engine
module i2cbe_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          scl_level,
  input logic                          sda_value,
  input logic                          busy_res,
  input logic                          done_res,
  input logic [i2cbe_pkg::BYTE_W-1:0]  rx_byte
);
  import i2cbe_pkg::*;

  // result register empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result pending after reset");

  // input stalls only behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a stalled result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(rx_byte) && $stable(done_res)))
    else $error("stalled result changed");

  // a completing command leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && done_res) |-> !busy_res)
    else $error("done while busy");

  // only a stop completes with scl high, and it ends with sda high
  a_done_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && done_res) |-> (!scl_level || sda_value))
    else $error("command ended with scl high and sda low");

endmodule

bind i2c_master_bit_engine i2cbe_checker u_i2cbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .scl_level (out_ch.scl_level),
  .sda_value (out_ch.sda_value),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res),
  .rx_byte   (out_ch.rx_byte)
);
